### rtl/sensor_frame_crc_check_convert_assert.svh
// ----------------------------------------------------------------------------
// Sensor frame CRC check and convert: assertion macros
// Shared concurrent assertion forms used at the end of the queue and converter modules.
// ----------------------------------------------------------------------------
`ifndef SENSOR_FRAME_CRC_CHECK_CONVERT_ASSERT_SVH
`define SENSOR_FRAME_CRC_CHECK_CONVERT_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SFCC_ASSERT_NOW(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("sfcc assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define SFCC_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("sfcc assertion failed");

`endif

### rtl/sfcc_pkg.sv
// ----------------------------------------------------------------------------
// Sensor frame CRC check and convert: package
// Field widths, CRC and scaling constants, the measurement record and CRC-8.
// ----------------------------------------------------------------------------
package sfcc_pkg;

  localparam int BYTE_W = 8;
  localparam int WORD_W = 16;
  localparam int TEMP_W = 15;
  localparam int HUMI_W = 14;
  localparam int STAT_W = 2;

  localparam logic [7:0] CRC_GENERATOR = 8'h31;
  localparam logic [7:0] CRC_INIT = 8'hFF;

  localparam int TEMP_SCALE = 17500;
  localparam int HUMI_SCALE = 10000;
  localparam int TEMP_OFFSET = 4500;

  localparam int TEMP_PROD_W = 31;
  localparam int HUMI_PROD_W = 30;

  localparam int QUEUE_DEPTH_DEF = 2;

  typedef struct packed {
    logic [WORD_W-1:0] temp_word;
    logic [WORD_W-1:0] humi_word;
    logic [STAT_W-1:0] status;
  } meas_t;

  function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] c;
    c = crc ^ b;
    for (int k = 0; k < 8; k++) begin
      if (c[7]) begin
        c = {c[6:0], 1'b0} ^ CRC_GENERATOR;
      end else begin
        c = {c[6:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

### rtl/sfcc_if.sv
// ----------------------------------------------------------------------------
// Sensor frame CRC check and convert: channel interfaces
// Byte input channel and measurement result channel, valid/ready handshake.
// ----------------------------------------------------------------------------
interface sfcc_in_if import sfcc_pkg::*;;
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] rx_byte;
  logic              frame_start;

  modport source (output valid, rx_byte, frame_start, input ready);
  modport sink (input valid, rx_byte, frame_start, output ready);
endinterface

interface sfcc_out_if import sfcc_pkg::*;;
  logic                     valid;
  logic                     ready;
  logic signed [TEMP_W-1:0] temp_centi;
  logic [HUMI_W-1:0]        humi_centi;
  logic [STAT_W-1:0]        status;

  modport source (output valid, temp_centi, humi_centi, status, input ready);
  modport sink (input valid, temp_centi, humi_centi, status, output ready);
endinterface

### rtl/sensor_frame_crc_check_convert.sv
// ----------------------------------------------------------------------------
// Sensor frame CRC check and convert: top level
// Checks the two CRC-8 bytes of a six-byte measurement frame and converts it.
// ----------------------------------------------------------------------------
// One frame byte is accepted every cycle. Each sixth byte yields one result,
// which is registered in the queue, then in the product register behind the
// constant multipliers and then in the output register. The front end stalls
// only when the queue of QUEUE_DEPTH measurements ahead of the converter is
// full, which happens only while the result sink holds ready low.
module sensor_frame_crc_check_convert import sfcc_pkg::*; #(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic       clk,
  input  logic       rst,
  sfcc_in_if.sink    rx,
  sfcc_out_if.source meas
);

  logic  push_valid;
  logic  push_ready;
  meas_t push_data;
  logic  pop_valid;
  logic  pop_ready;
  meas_t pop_data;

  sfcc_front u_front (
    .clk        (clk),
    .rst        (rst),
    .rx         (rx),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data)
  );

  sfcc_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_data   (pop_data)
  );

  sfcc_back u_back (
    .clk       (clk),
    .rst       (rst),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_data  (pop_data),
    .meas      (meas)
  );

endmodule

### rtl/sfcc_front.sv
// ----------------------------------------------------------------------------
// Sensor frame CRC check and convert: front end
// Tracks the frame position, runs the CRC and collects one measurement.
// ----------------------------------------------------------------------------
module sfcc_front import sfcc_pkg::*; (
  input  logic   clk,
  input  logic   rst,
  sfcc_in_if.sink rx,
  output logic   push_valid,
  input  logic   push_ready,
  output meas_t  push_data
);

  typedef enum logic [2:0] {
    B_TEMP_MSB = 3'd0,
    B_TEMP_LSB = 3'd1,
    B_TEMP_CRC = 3'd2,
    B_HUMI_MSB = 3'd3,
    B_HUMI_LSB = 3'd4,
    B_HUMI_CRC = 3'd5
  } pos_t;

  pos_t              pos;
  pos_t              cur;
  logic [7:0]        crc_run;
  logic [7:0]        crc_cur;
  logic [WORD_W-1:0] temp_word;
  logic [7:0]        humi_high;
  logic [WORD_W-1:0] humi_word;
  logic              temp_crc_bad;
  logic              accept;

  assign cur     = rx.frame_start ? B_TEMP_MSB : pos;
  assign crc_cur = rx.frame_start ? CRC_INIT : crc_run;
  assign accept  = rx.valid && rx.ready;

  assign rx.ready   = push_ready;
  assign push_valid = rx.valid && (cur == B_HUMI_CRC);
  assign push_data  = '{temp_word: temp_word, humi_word: humi_word,
                        status: {crc_cur != rx.rx_byte, temp_crc_bad}};

  always_ff @(posedge clk) begin
    if (rst) begin
      pos          <= B_TEMP_MSB;
      crc_run      <= CRC_INIT;
      temp_crc_bad <= 1'b0;
    end else if (accept) begin
      case (cur)
        B_TEMP_LSB: begin
          crc_run        <= crc8_byte(crc_cur, rx.rx_byte);
          temp_word[7:0] <= rx.rx_byte;
          pos            <= B_TEMP_CRC;
        end
        B_TEMP_CRC: begin
          temp_crc_bad <= (crc_cur != rx.rx_byte);
          crc_run      <= CRC_INIT;
          pos          <= B_HUMI_MSB;
        end
        B_HUMI_MSB: begin
          crc_run   <= crc8_byte(CRC_INIT, rx.rx_byte);
          humi_high <= rx.rx_byte;
          pos       <= B_HUMI_LSB;
        end
        B_HUMI_LSB: begin
          crc_run   <= crc8_byte(crc_cur, rx.rx_byte);
          humi_word <= {humi_high, rx.rx_byte};
          pos       <= B_HUMI_CRC;
        end
        B_HUMI_CRC: begin
          crc_run <= CRC_INIT;
          pos     <= B_TEMP_MSB;
        end
        default: begin
          crc_run   <= crc8_byte(CRC_INIT, rx.rx_byte);
          temp_word <= {rx.rx_byte, 8'h00};
          pos       <= B_TEMP_LSB;
        end
      endcase
    end
  end

endmodule

### rtl/sfcc_queue.sv
// ----------------------------------------------------------------------------
// Sensor frame CRC check and convert: measurement queue
// Small first-in first-out buffer between the front end and the converter.
// ----------------------------------------------------------------------------
`include "sensor_frame_crc_check_convert_assert.svh"

module sfcc_queue import sfcc_pkg::*; #(
  parameter int DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic  clk,
  input  logic  rst,
  input  logic  push_valid,
  output logic  push_ready,
  input  meas_t push_data,
  output logic  pop_valid,
  input  logic  pop_ready,
  output meas_t pop_data
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  meas_t         mem [DEPTH];
  logic [AW-1:0] wr_ptr;
  logic [AW-1:0] rd_ptr;
  logic [CW-1:0] count;
  logic          push;
  logic          pop;

  assign push_ready = (count != CW'(DEPTH));
  assign pop_valid  = (count != '0);
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;
  assign pop_data   = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  `SFCC_ASSERT_NOW(a_count_bound, clk, rst, 1'b1, count <= CW'(DEPTH))
  `SFCC_ASSERT_NEXT(a_count_up, clk, rst, push && !pop, count == $past(count) + 1'b1)
  `SFCC_ASSERT_NEXT(a_count_down, clk, rst, pop && !push, count == $past(count) - 1'b1)

endmodule

### rtl/sfcc_back.sv
// ----------------------------------------------------------------------------
// Sensor frame CRC check and convert: converter
// Scales the raw words to hundredths and holds the result for the sink.
// ----------------------------------------------------------------------------
`include "sensor_frame_crc_check_convert_assert.svh"

module sfcc_back import sfcc_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      pop_valid,
  output logic      pop_ready,
  input  meas_t     pop_data,
  sfcc_out_if.source meas
);

  logic                   prod_valid;
  logic [TEMP_PROD_W-1:0] temp_prod;
  logic [HUMI_PROD_W-1:0] humi_prod;
  logic [STAT_W-1:0]      prod_status;
  logic                   out_load;
  logic                   prod_load;
  logic signed [TEMP_W:0] temp_wide;

  assign out_load  = !meas.valid || meas.ready;
  assign prod_load = !prod_valid || out_load;
  assign pop_ready = prod_load;

  assign temp_wide = $signed({1'b0, temp_prod[TEMP_PROD_W-1:WORD_W]})
                     - $signed((TEMP_W + 1)'(TEMP_OFFSET));

  always_ff @(posedge clk) begin
    if (rst) begin
      prod_valid <= 1'b0;
      meas.valid <= 1'b0;
    end else begin
      if (prod_load) begin
        prod_valid <= pop_valid;
      end
      if (out_load) begin
        meas.valid <= prod_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (prod_load && pop_valid) begin
      temp_prod   <= TEMP_PROD_W'(pop_data.temp_word) * TEMP_PROD_W'(TEMP_SCALE);
      humi_prod   <= HUMI_PROD_W'(pop_data.humi_word) * HUMI_PROD_W'(HUMI_SCALE);
      prod_status <= pop_data.status;
    end
    if (out_load && prod_valid) begin
      meas.temp_centi <= temp_wide[TEMP_W-1:0];
      meas.humi_centi <= humi_prod[HUMI_PROD_W-1:WORD_W];
      meas.status     <= prod_status;
    end
  end

  `SFCC_ASSERT_NEXT(a_prod_hold, clk, rst, prod_valid && !out_load,
                    prod_valid && $stable(temp_prod) && $stable(prod_status))

endmodule
